/* hdl/ppn_pkg.sv */
// ----------------------------------------------------------------------------
// ppn_pkg
// Types and constants shared by the projective pair normalizer.
// ----------------------------------------------------------------------------
package ppn_pkg;

  localparam int MOD_BITS_DEF = 32;

  typedef struct packed {
    logic signed [63:0] first_coord;
    logic signed [63:0] second_coord;
  } ppn_in_t;

  typedef struct packed {
    logic [31:0] norm_first;
    logic [31:0] norm_second;
    logic [31:0] unit_scalar;
    logic        is_valid;
  } ppn_out_t;

  typedef enum logic [1:0] {
    ALU_MOD,
    ALU_MULMOD,
    ALU_GCD
  } alu_cmd_t;

  typedef struct packed {
    logic     start;
    alu_cmd_t cmd;
  } alu_req_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_GCD
  } alu_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED_U,
    S_RED_U_W,
    S_RED_V,
    S_RED_V_W,
    S_ZG,
    S_ZG_W,
    S_EG_CHK,
    S_EG_DIV,
    S_EG_DIV_W,
    S_EG_MUL,
    S_EG_MUL_W,
    S_GV,
    S_GV_W,
    S_D_DIV,
    S_D_DIV_W,
    S_SC_GCD,
    S_SC_GCD_W,
    S_V_MUL,
    S_V_MUL_W,
    S_STEP,
    S_STEP_W,
    S_SRCH,
    S_T_GCD,
    S_T_GCD_W,
    S_PROD,
    S_PROD_W,
    S_OUT
  } ppn_state_t;

endpackage

/* hdl/ppn_alu.sv */
// ----------------------------------------------------------------------------
// ppn_alu
// Shared restoring divider with modular multiply and Euclid gcd sequencing.
// ----------------------------------------------------------------------------
module ppn_alu #(
  parameter int W = ppn_pkg::MOD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ppn_pkg::alu_req_t req,
  input  logic [63:0]       opa,
  input  logic [W-1:0]      opb,
  input  logic [W-1:0]      modulus,
  output logic              done,
  output logic [W-1:0]      res,
  output logic [W-1:0]      quot
);
  import ppn_pkg::*;

  localparam int CW = 7;

  alu_state_t      state, state_next;
  alu_cmd_t        cmd;
  logic [63:0]     dq;
  logic [W-1:0]    rem;
  logic [W-1:0]    dsr;
  logic [CW-1:0]   cnt;
  logic [W-1:0]    gx;
  logic [W-1:0]    gy;

  logic            ld;
  logic [63:0]     ld_dividend;
  logic [W-1:0]    ld_divisor;
  logic            div_last;
  logic            gcd_done;
  logic [W:0]      shifted;
  logic            ge;
  logic [W-1:0]    rem_next;
  logic [2*W-1:0]  prod;

  assign prod     = opa[W-1:0] * opb;
  assign shifted  = {rem, dq[63]};
  assign ge       = shifted >= {1'b0, dsr};
  assign rem_next = ge ? W'(shifted - {1'b0, dsr}) : shifted[W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      A_IDLE: begin
        if (req.start) state_next = (req.cmd == ALU_GCD) ? A_GCD : A_DIV;
      end
      A_DIV: begin
        if (cnt == CW'(1)) state_next = (cmd == ALU_GCD) ? A_GCD : A_IDLE;
      end
      A_GCD: begin
        state_next = (gy == '0) ? A_IDLE : A_DIV;
      end
      default: state_next = A_IDLE;
    endcase
  end

  always_comb begin
    ld          = 1'b0;
    ld_dividend = 64'(gx);
    ld_divisor  = gy;
    div_last    = (state == A_DIV) && (cnt == CW'(1));
    gcd_done    = (state == A_GCD) && (gy == '0);
    case (state)
      A_IDLE: begin
        if (req.start && req.cmd == ALU_MOD) begin
          ld          = 1'b1;
          ld_dividend = opa;
          ld_divisor  = opb;
        end else if (req.start && req.cmd == ALU_MULMOD) begin
          ld          = 1'b1;
          ld_dividend = 64'(prod);
          ld_divisor  = modulus;
        end
      end
      A_GCD: begin
        ld = (gy != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (div_last && cmd != ALU_GCD) || gcd_done;
    end
  end

  always_ff @(posedge clk) begin
    if (state == A_IDLE && req.start) begin
      cmd <= req.cmd;
      gx  <= opa[W-1:0];
      gy  <= opb;
    end
    if (ld) begin
      rem <= '0;
      dsr <= ld_divisor;
      if (ld_dividend[63:W] == '0) begin
        dq  <= ld_dividend << (64 - W);
        cnt <= CW'(W);
      end else begin
        dq  <= ld_dividend;
        cnt <= CW'(64);
      end
    end else if (state == A_DIV) begin
      rem <= rem_next;
      dq  <= {dq[62:0], ge};
      cnt <= cnt - CW'(1);
      if (div_last && cmd == ALU_GCD) begin
        gx <= dsr;
        gy <= rem_next;
      end
    end
  end

  assign res  = (cmd == ALU_GCD) ? gx : rem;
  assign quot = dq[W-1:0];

endmodule

/* hdl/projective_pair_normalizer.sv */
// ----------------------------------------------------------------------------
// projective_pair_normalizer
// Canonical representative of a pair on the projective line over Z/NZ.
// ----------------------------------------------------------------------------
// Sequence: for N <= 1 straight to the output; otherwise a sum over shared-divider
//   runs (input reductions, Euclid steps, modular products), plus a search
//   step per candidate and a gcd per new minimum.
// Throughput: one transaction at a time; the next is taken once the sequencer
//   is idle again. Reset: modulus 1, sequencer idle, output register empty.
module projective_pair_normalizer #(
  parameter int MOD_BITS = ppn_pkg::MOD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [31:0]      cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  ppn_pkg::ppn_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ppn_pkg::ppn_out_t out_data
);
  import ppn_pkg::*;

  localparam int W = MOD_BITS;

  ppn_state_t   state, state_next;
  logic [W-1:0] n;
  logic [63:0]  raw_u, raw_v;
  logic [W-1:0] u, v, g, r0, r1, s0, s1, q, scale, d;
  logic [W-1:0] min_v, min_t, t, step, k;
  logic         fin;
  logic [W-1:0] res_first, res_second, res_scalar;
  logic         res_valid;

  alu_req_t     req;
  logic [63:0]  opa;
  logic [W-1:0] opb;
  logic         alu_done;
  logic [W-1:0] alu_res, alu_quot;

  logic         in_take;
  logic         out_load;
  logic         neg;
  logic [W-1:0] fixed, sub_s, add_v, add_t, add_sc;

  function automatic logic [W-1:0] addmod(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : s[W-1:0];
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  ppn_alu #(.W(W)) u_alu (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .opa     (opa),
    .opb     (opb),
    .modulus (n),
    .done    (alu_done),
    .res     (alu_res),
    .quot    (alu_quot)
  );

  assign in_take  = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);
  assign neg      = (state == S_RED_U_W) ? raw_u[63] : raw_v[63];
  assign fixed    = (neg && alu_res != '0) ? W'(n - alu_res) : alu_res;
  assign sub_s    = (s0 >= alu_res) ? W'(s0 - alu_res) : W'(s0 + n - alu_res);
  assign add_v    = addmod(v, step, n);
  assign add_t    = addmod(t, d, n);
  assign add_sc   = addmod(scale, d, n);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_take) state_next = (n <= W'(1)) ? S_OUT : S_RED_U;
      S_RED_U:    state_next = S_RED_U_W;
      S_RED_U_W:  if (alu_done) state_next = S_RED_V;
      S_RED_V:    state_next = S_RED_V_W;
      S_RED_V_W:  if (alu_done) state_next = (u == '0) ? S_ZG : S_EG_CHK;
      S_ZG:       state_next = S_ZG_W;
      S_ZG_W:     if (alu_done) state_next = S_OUT;
      S_EG_CHK: begin
        if (r1 != '0) state_next = S_EG_DIV;
        else state_next = fin ? S_OUT : S_GV;
      end
      S_EG_DIV:   state_next = S_EG_DIV_W;
      S_EG_DIV_W: if (alu_done) state_next = S_EG_MUL;
      S_EG_MUL:   state_next = S_EG_MUL_W;
      S_EG_MUL_W: if (alu_done) state_next = S_EG_CHK;
      S_GV:       state_next = S_GV_W;
      S_GV_W: begin
        if (alu_done) begin
          if (alu_res != W'(1)) state_next = S_OUT;
          else state_next = (g == W'(1)) ? S_V_MUL : S_D_DIV;
        end
      end
      S_D_DIV:    state_next = S_D_DIV_W;
      S_D_DIV_W:  if (alu_done) state_next = S_SC_GCD;
      S_SC_GCD:   state_next = S_SC_GCD_W;
      S_SC_GCD_W: if (alu_done) state_next = (alu_res == W'(1)) ? S_V_MUL : S_SC_GCD;
      S_V_MUL:    state_next = S_V_MUL_W;
      S_V_MUL_W:  if (alu_done) state_next = (g == W'(1)) ? S_PROD : S_STEP;
      S_STEP:     state_next = S_STEP_W;
      S_STEP_W:   if (alu_done) state_next = S_SRCH;
      S_SRCH: begin
        if (add_v < min_v) state_next = S_T_GCD;
        else if (k == g) state_next = S_PROD;
      end
      S_T_GCD:    state_next = S_T_GCD_W;
      S_T_GCD_W:  if (alu_done) state_next = (k == g) ? S_PROD : S_SRCH;
      S_PROD:     state_next = S_PROD_W;
      S_PROD_W:   if (alu_done) state_next = S_EG_CHK;
      S_OUT:      if (out_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.start = 1'b0;
    req.cmd   = ALU_MOD;
    opa       = '0;
    opb       = '0;
    in_stall  = (state != S_IDLE);
    case (state)
      S_RED_U:  begin req = '{1'b1, ALU_MOD};    opa = mag(raw_u);  opb = n; end
      S_RED_V:  begin req = '{1'b1, ALU_MOD};    opa = mag(raw_v);  opb = n; end
      S_ZG:     begin req = '{1'b1, ALU_GCD};    opa = 64'(v);      opb = n; end
      S_EG_DIV: begin req = '{1'b1, ALU_MOD};    opa = 64'(r0);     opb = r1; end
      S_EG_MUL: begin req = '{1'b1, ALU_MULMOD}; opa = 64'(q);      opb = s1; end
      S_GV:     begin req = '{1'b1, ALU_GCD};    opa = 64'(g);      opb = v; end
      S_D_DIV:  begin req = '{1'b1, ALU_MOD};    opa = 64'(n);      opb = g; end
      S_SC_GCD: begin req = '{1'b1, ALU_GCD};    opa = 64'(scale);  opb = n; end
      S_V_MUL:  begin req = '{1'b1, ALU_MULMOD}; opa = 64'(scale);  opb = v; end
      S_STEP:   begin req = '{1'b1, ALU_MULMOD}; opa = 64'(v);      opb = d; end
      S_T_GCD:  begin req = '{1'b1, ALU_GCD};    opa = 64'(t);      opb = n; end
      S_PROD:   begin req = '{1'b1, ALU_MULMOD}; opa = 64'(scale);  opb = min_t; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) n <= cfg_wdata[W-1:0];
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.norm_first  <= 32'(res_first);
      out_data.norm_second <= 32'(res_second);
      out_data.unit_scalar <= 32'(res_scalar);
      out_data.is_valid    <= res_valid;
    end
    case (state)
      S_IDLE: begin
        if (in_take) begin
          raw_u      <= in_data.first_coord;
          raw_v      <= in_data.second_coord;
          res_first  <= '0;
          res_second <= '0;
          res_scalar <= W'(1);
          res_valid  <= 1'b1;
        end
      end
      S_RED_U_W: if (alu_done) u <= fixed;
      S_RED_V_W: begin
        if (alu_done) begin
          v   <= fixed;
          r0  <= u;
          r1  <= n;
          s0  <= W'(1);
          s1  <= '0;
          fin <= 1'b0;
        end
      end
      S_ZG_W: begin
        if (alu_done) begin
          res_first  <= '0;
          res_second <= W'(alu_res == W'(1));
          res_scalar <= v;
          res_valid  <= (alu_res == W'(1));
        end
      end
      S_EG_CHK: begin
        if (r1 == '0) begin
          if (fin) begin
            res_scalar <= (r0 == W'(1)) ? s0 : '0;
            res_valid  <= (r0 == W'(1));
          end else begin
            g     <= r0;
            scale <= s0;
          end
        end
      end
      S_EG_DIV_W: begin
        if (alu_done) begin
          q  <= alu_quot;
          r0 <= r1;
          r1 <= alu_res;
        end
      end
      S_EG_MUL_W: begin
        if (alu_done) begin
          s0 <= s1;
          s1 <= sub_s;
        end
      end
      S_GV_W: begin
        if (alu_done && alu_res != W'(1)) begin
          res_first  <= '0;
          res_second <= '0;
          res_scalar <= '0;
          res_valid  <= 1'b0;
        end
      end
      S_D_DIV_W:  if (alu_done) d <= alu_quot;
      S_SC_GCD_W: if (alu_done && alu_res != W'(1)) scale <= add_sc;
      S_V_MUL_W: begin
        if (alu_done) begin
          v     <= alu_res;
          min_v <= alu_res;
          min_t <= W'(1);
        end
      end
      S_STEP_W: begin
        if (alu_done) begin
          step <= alu_res;
          t    <= W'(1);
          k    <= W'(2);
        end
      end
      S_SRCH: begin
        v <= add_v;
        t <= add_t;
        if (!(add_v < min_v) && k != g) k <= k + W'(1);
      end
      S_T_GCD_W: begin
        if (alu_done) begin
          if (alu_res == W'(1)) begin
            min_v <= v;
            min_t <= t;
          end
          if (k != g) k <= k + W'(1);
        end
      end
      S_PROD_W: begin
        if (alu_done) begin
          r0         <= alu_res;
          r1         <= n;
          s0         <= W'(1);
          s1         <= '0;
          fin        <= 1'b1;
          res_first  <= g;
          res_second <= min_v;
        end
      end
      default: ;
    endcase
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for projective_pair_normalizer: an internal model of
// the projective line over Z/NZ predicts every result, which is checked in
// order against the block under random valid/stall traffic and several
// moduli, from the trivial level up to the widest.
// ----------------------------------------------------------------------------
module tb;
  import ppn_pkg::*;

  localparam int MAX_GCD = 4096;

  class ppn_scoreboard;
    logic [31:0] modulus;
    ppn_out_t    pending[$];

    function new();
      modulus = 32'd1;
    endfunction

    function logic [31:0] gcd32(logic [31:0] a, logic [31:0] b);
      logic [31:0] r;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      return a;
    endfunction

    function logic [31:0] ext_gcd(logic [31:0] a, logic [31:0] n, output longint coef);
      longint r0, r1, s0, s1, q, r2, s2;
      r0 = a; r1 = n; s0 = 1; s1 = 0;
      while (r1 != 0) begin
        q = r0 / r1;
        r2 = r0 - q * r1;
        s2 = s0 - q * s1;
        r0 = r1; r1 = r2;
        s0 = s1; s1 = s2;
      end
      coef = s0;
      return r0[31:0];
    endfunction

    function logic [31:0] reduce(logic [63:0] bits, logic [31:0] n);
      logic [63:0] mag, r;
      if (bits[63]) begin
        mag = ~bits + 64'd1;
        r = mag % {32'd0, n};
        return (r == 0) ? 32'd0 : n - r[31:0];
      end
      r = bits % {32'd0, n};
      return r[31:0];
    endfunction

    function logic [31:0] mulmod(logic [31:0] a, logic [31:0] b, logic [31:0] n);
      logic [63:0] p;
      p = ({32'd0, a} * {32'd0, b}) % {32'd0, n};
      return p[31:0];
    endfunction

    function logic [31:0] addmod(logic [31:0] a, logic [31:0] b, logic [31:0] n);
      logic [63:0] s;
      s = ({32'd0, a} + {32'd0, b}) % {32'd0, n};
      return s[31:0];
    endfunction

    function ppn_out_t normalize(ppn_in_t x);
      ppn_out_t    r;
      logic [31:0] n, u, v, g, scale, min_v, min_t, d, q, t, stp, prod, ig;
      logic [63:0] k;
      longint      coef;
      n = modulus;
      r = '0;
      if (n <= 1) begin
        r.unit_scalar = 32'd1;
        r.is_valid = 1'b1;
        return r;
      end
      u = reduce(x.first_coord, n);
      v = reduce(x.second_coord, n);
      if (u == 0) begin
        r.norm_second = (gcd32(v, n) == 1) ? 32'd1 : 32'd0;
        r.unit_scalar = v;
        r.is_valid = r.norm_second[0];
        return r;
      end
      g = ext_gcd(u, n, coef);
      if (gcd32(g, v) != 1) return r;
      scale = reduce(coef, n);
      if (g != 1) begin
        d = n / g;
        while (gcd32(scale, n) != 1) scale = addmod(scale, d, n);
      end
      v = mulmod(scale, v, n);
      min_v = v;
      min_t = 32'd1;
      if (g != 1) begin
        q = n / g;
        t = 32'd1;
        stp = mulmod(v, q, n);
        for (k = 2; k <= g; k++) begin
          v = addmod(v, stp, n);
          t = addmod(t, q, n);
          if (v < min_v && gcd32(t, n) == 1) begin
            min_v = v;
            min_t = t;
          end
        end
      end
      r.norm_first = g;
      r.norm_second = min_v;
      prod = mulmod(scale, min_t, n);
      ig = ext_gcd(prod, n, coef);
      if (ig == 1) begin
        r.unit_scalar = reduce(coef, n);
        r.is_valid = 1'b1;
      end
      return r;
    endfunction

    function void note_input(ppn_in_t x);
      pending.push_back(normalize(x));
    endfunction

    // returns an empty string when the result matches
    function string check_result(ppn_out_t got);
      ppn_out_t e;
      string    s;
      if (pending.size() == 0) return $sformatf("unexpected result %h", got);
      e = pending.pop_front();
      s = "";
      if (got.norm_first !== e.norm_first)
        s = {s, $sformatf(" norm_first %0d/%0d", got.norm_first, e.norm_first)};
      if (got.norm_second !== e.norm_second)
        s = {s, $sformatf(" norm_second %0d/%0d", got.norm_second, e.norm_second)};
      if (got.unit_scalar !== e.unit_scalar)
        s = {s, $sformatf(" unit_scalar %0d/%0d", got.unit_scalar, e.unit_scalar)};
      if (got.is_valid !== e.is_valid)
        s = {s, $sformatf(" is_valid %0b/%0b", got.is_valid, e.is_valid)};
      if (s != "") s = {$sformatf("N=%0d got/exp:", modulus), s};
      return s;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ppn_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ppn_out_t    out_data;

  ppn_scoreboard sb = new();
  int  errors = 0;
  bit  no_idle = 0;
  bit  hold_long = 0;

  projective_pair_normalizer dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report(string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  always @(posedge clk) begin
    string m;
    if (!rst && in_valid && !in_stall) sb.note_input(in_data);
    if (!rst && out_valid && !out_stall) begin
      m = sb.check_result(out_data);
      if (m != "") report(m);
    end
  end

  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        hold_long = 0;
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
      end
      g = draw_gap();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send(logic [63:0] u, logic [63:0] v);
    int g;
    g = draw_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.first_coord <= u;
    in_data.second_coord <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_modulus(logic [31:0] m);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.modulus = m;
  endtask

  function automatic logic [63:0] pick_coord(logic [31:0] n);
    case ($urandom_range(0, 5))
      0, 1: return {$urandom, $urandom};
      2: return 64'($signed($urandom_range(0, 100)) - 50);
      3: return 64'(n) * $urandom_range(0, 7) + $urandom_range(0, 3);
      4: return 64'(n / ($urandom_range(1, 6))) * $urandom_range(0, 4);
      default: begin
        case ($urandom_range(0, 3))
          0: return 64'h8000_0000_0000_0000;
          1: return 64'h7FFF_FFFF_FFFF_FFFF;
          2: return 64'hFFFF_FFFF_FFFF_FFFF;
          default: return 64'd0;
        endcase
      end
    endcase
  endfunction

  task automatic send_random(logic [31:0] n);
    logic [63:0] u, v;
    do u = pick_coord(n);
    while (n > 1 && sb.gcd32(sb.reduce(u, n), n) > MAX_GCD);
    v = pick_coord(n);
    send(u, v);
  endtask

  task automatic send_directed();
    send(64'd0, 64'd5);
    send(64'd0, 64'd4);
    send(64'd2, 64'd2);
    send(64'd4, 64'd3);
    send(64'd3, 64'd5);
    send(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  initial begin
    logic [31:0] mods[10];
    logic [31:0] m;
    mods = '{32'd1, 32'd12, 32'hFFFF_FFFF, 32'd2, 32'd360, 32'd1000003,
             32'd4294967291, 32'h8000_0000, 32'd0, 32'd1};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    for (int p = 0; p < 10; p++) begin
      m = mods[p];
      if (p == 8) begin
        m = $urandom;
        if (m < 2) m = 32'd7;
      end
      set_modulus(m);
      no_idle = (p == 2);
      if (p == 4) hold_long = 1;
      if (p < 3) send_directed();
      for (int i = 0; i < 120; i++) send_random(m);
    end
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(64'd2_000_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
